>>> sv/clld_pkg.sv
// Shared constants and controller/datapath interface types for the CR LF line deframer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package clld_pkg;

  localparam int MAX_CMD_LENGTH = 64;
  localparam int LINE_CAP = MAX_CMD_LENGTH - 1;
  localparam int CNT_W = $clog2(LINE_CAP + 1);
  localparam int ADDR_W = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  typedef struct packed {
    logic load_byte;
    logic set_pending;
    logic clr_pending;
    logic put_cr;
    logic put_byte;
    logic clr_line;
    logic rd_start;
    logic rd_en;
    logic out_load;
  } clld_cmd_t;

  typedef struct packed {
    logic pending;
    logic is_cr;
    logic is_lf;
    logic line_empty;
    logic overflow;
    logic out_busy;
    logic rd_last;
  } clld_status_t;

endpackage

>>> sv/clld_datapath.sv
// Datapath of the CR LF line deframer: received-word register, line memory, count,
// flags, read index and the output register. Depends on clld_pkg.
module clld_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clld_pkg::clld_cmd_t  cmd,
  output clld_pkg::clld_status_t st,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_cmd_byte,
  output logic                 out_is_last
);

  logic [7:0] line_mem [clld_pkg::LINE_CAP];
  logic [7:0] mem_q_r;
  logic [7:0] byte_r;
  logic [clld_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [clld_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic pending_r, pending_nxt;
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic out_last_r;
  logic put;
  logic full;
  logic wr_en;
  logic [7:0] wr_data;

  assign put = cmd.put_cr | cmd.put_byte;
  assign full = (count_r == clld_pkg::CNT_W'(clld_pkg::LINE_CAP));
  assign wr_en = put && !ovf_r && !full;
  assign wr_data = cmd.put_cr ? clld_pkg::BYTE_CR : byte_r;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    pending_nxt = pending_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r;
    if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
    if (put && !ovf_r && full) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.clr_line) begin
      count_nxt = '0;
      ovf_nxt = 1'b0;
    end
    if (cmd.clr_pending) begin
      pending_nxt = 1'b0;
    end
    if (cmd.set_pending) begin
      pending_nxt = 1'b1;
    end
    if (cmd.rd_start) begin
      idx_nxt = '0;
    end else if (cmd.out_load) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r <= 1'b0;
      pending_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
      pending_r <= pending_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_rx_byte;
    end
    if (cmd.out_load) begin
      out_byte_r <= mem_q_r;
      out_last_r <= st.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count_r[clld_pkg::ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q_r <= line_mem[idx_r[clld_pkg::ADDR_W-1:0]];
    end
  end

  assign st.pending = pending_r;
  assign st.is_cr = (byte_r == clld_pkg::BYTE_CR);
  assign st.is_lf = (byte_r == clld_pkg::BYTE_LF);
  assign st.line_empty = (count_r == '0);
  assign st.overflow = ovf_r;
  assign st.out_busy = out_valid_r && !out_ready;
  assign st.rd_last = ((idx_r + 1'b1) == count_r);

  assign out_valid = out_valid_r;
  assign out_cmd_byte = out_byte_r;
  assign out_is_last = out_last_r;

endmodule

>>> sv/clld_ctrl.sv
// Controller of the CR LF line deframer: sequences the handling of one received word
// and the read-out of a finished line. Depends on clld_pkg.
module clld_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  clld_pkg::clld_status_t st,
  output clld_pkg::clld_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_BYTE,
    S_RD,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.pending) begin
          cmd.clr_pending = 1'b1;
          if (st.is_lf) begin
            if (!st.overflow && !st.line_empty) begin
              cmd.rd_start = 1'b1;
              state_nxt = S_RD;
            end else begin
              cmd.clr_line = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.put_cr = 1'b1;
            state_nxt = S_BYTE;
          end
        end else begin
          if (st.is_cr) begin
            cmd.set_pending = 1'b1;
          end else begin
            cmd.put_byte = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_BYTE: begin
        if (st.is_cr) begin
          cmd.set_pending = 1'b1;
        end else begin
          cmd.put_byte = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          if (st.rd_last) begin
            cmd.clr_line = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/crlf_line_deframer_unit.sv
// Top level of the CR LF line deframer: joins the controller and the datapath.
// Depends on clld_pkg, clld_ctrl and clld_datapath.
//
// Received bytes are gathered into a 63-byte line memory until CR LF ends the line; a
// lone CR counts as a line byte, empty lines give nothing and overlong lines are
// dropped. Each received word passes S_IDLE and S_EVAL, plus S_BYTE when a held CR
// turns out to be a line byte, since the line memory has a single write port. On CR
// LF a stored line is read out word by word in two steps (memory read, then output
// register load, which waits on a busy output); the input stays closed until the last
// word is loaded; it may then wait at the output while a new received word is taken.
module crlf_line_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cmd_byte,
  output logic       out_is_last
);

  clld_pkg::clld_cmd_t    cmd;
  clld_pkg::clld_status_t st;

  clld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  clld_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cmd_byte (out_cmd_byte),
    .out_is_last  (out_is_last)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again before the previous word was handled");

  a_readout_only_valid_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_start |-> !st.overflow && !st.line_empty)
    else $error("read-out started for an empty or dropped line");

  a_last_word_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && st.rd_last |=> in_ready && st.line_empty)
    else $error("line not cleared after its last word was loaded");

  a_no_load_over_pending_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten while its word waits");

endmodule
